// File: hw/rtl/bpc_pkg.sv
// ---------------------------------------------------------------------------
// bpc_pkg
// shared widths, register indexes and helpers of the pressure compensation
// ---------------------------------------------------------------------------
package bpc_pkg;

    localparam int DW = 32;
    localparam int CFG_DW = 64;
    localparam int CFG_IW = 2;
    localparam int UT_W = 16;
    localparam int UP_W = 19;
    localparam int TO_W = 16;

    typedef enum logic [CFG_IW-1:0] {
        REG_CAL_A = 2'd0,
        REG_CAL_B = 2'd1,
        REG_CAL_C = 2'd2,
        REG_OSS   = 2'd3
    } t_reg_idx;

    localparam logic [DW-1:0] T6_OFS    = 32'd4000;
    localparam logic [DW-1:0] K_SQ      = 32'd3038;
    localparam logic [DW-1:0] K_LIN     = 32'hFFFF_E343; // -7357
    localparam logic [DW-1:0] K_OFS     = 32'd3791;
    localparam logic [DW-1:0] S_OFS     = 32'd32768;
    localparam logic [DW-1:0] P_SCALE   = 32'd50000;
    localparam logic [DW-1:0] SIGN_BIT  = 32'h8000_0000;

    function automatic logic [DW-1:0] sx16(input logic [15:0] v);
        return {{(DW-16){v[15]}}, v};
    endfunction

    function automatic logic [DW-1:0] sra(input logic [DW-1:0] v, input int unsigned n);
        return DW'($signed(v) >>> n);
    endfunction

endpackage

// File: hw/rtl/bpc_in_if.sv
// ---------------------------------------------------------------------------
// bpc_in_if
// raw reading channel
// ---------------------------------------------------------------------------
interface bpc_in_if;
    logic                      valid;
    logic                      ready;
    logic [bpc_pkg::UT_W-1:0]  raw_temperature;
    logic [bpc_pkg::UP_W-1:0]  raw_pressure;

    modport source (output valid, raw_temperature, raw_pressure, input ready);
    modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

// File: hw/rtl/bpc_out_if.sv
// ---------------------------------------------------------------------------
// bpc_out_if
// compensated result channel
// ---------------------------------------------------------------------------
interface bpc_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [bpc_pkg::TO_W-1:0]  temperature_decidegrees;
    logic signed [bpc_pkg::DW-1:0]    pressure_pascal;
    logic                             divide_error;

    modport source (output valid, temperature_decidegrees, pressure_pascal, divide_error,
                    input ready);
    modport sink   (input valid, temperature_decidegrees, pressure_pascal, divide_error,
                    output ready);
endinterface

// File: hw/rtl/bpc_div.sv
// ---------------------------------------------------------------------------
// bpc_div
// pipelined restoring unsigned divider, one quotient bit per stage
// ---------------------------------------------------------------------------
module bpc_div #(
    parameter int SB_W = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_vld,
    input  logic [bpc_pkg::DW-1:0]   i_num,
    input  logic [bpc_pkg::DW-1:0]   i_den,
    input  logic [SB_W-1:0]          i_sb,
    output logic                     o_vld,
    output logic [bpc_pkg::DW-1:0]   o_quo,
    output logic [SB_W-1:0]          o_sb
);
    import bpc_pkg::*;

    localparam int N = DW;

    logic [N-1:0]        r_v;
    logic [DW:0]         r_rem [N];
    logic [DW-1:0]       r_num [N];
    logic [DW-1:0]       r_den [N];
    logic [SB_W-1:0]     r_sb  [N];

    logic [DW:0]         n_rem [N];
    logic [DW-1:0]       n_num [N];

    always_comb begin
        logic [DW:0]   rem_in;
        logic [DW-1:0] num_in;
        logic [DW-1:0] den_in;
        logic [DW:0]   sh;
        for (int k = 0; k < N; k++) begin
            rem_in = (k == 0) ? '0 : r_rem[(k == 0) ? 0 : k-1];
            num_in = (k == 0) ? i_num : r_num[(k == 0) ? 0 : k-1];
            den_in = (k == 0) ? i_den : r_den[(k == 0) ? 0 : k-1];
            sh = {rem_in[DW-1:0], num_in[DW-1]};
            if (sh >= {1'b0, den_in}) begin
                n_rem[k] = sh - {1'b0, den_in};
                n_num[k] = {num_in[DW-2:0], 1'b1};
            end else begin
                n_rem[k] = sh;
                n_num[k] = {num_in[DW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[N-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_rem[k] <= n_rem[k];
                r_num[k] <= n_num[k];
                r_den[k] <= (k == 0) ? i_den : r_den[(k == 0) ? 0 : k-1];
                r_sb[k]  <= (k == 0) ? i_sb : r_sb[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign o_vld = r_v[N-1];
    assign o_quo = r_num[N-1];
    assign o_sb  = r_sb[N-1];

endmodule

// File: hw/rtl/barometric_pressure_compensation.sv
// Compensates one raw temperature and one raw pressure reading per beat and
// returns temperature in 0.1 degree C and pressure in pascals. A new beat is
// taken every cycle while the output is not stalled; the path runs through two
// 32-stage pipelined dividers (temperature term and pressure term) and the
// multiply stages around them. The whole pipeline holds while a finished result
// waits at the output. Calibration words and oversampling are written through the
// config port; the user must do so only while no beat is in flight, as the block
// itself does not enforce it. A zero divisor returns zeros and the error flag.
// ---------------------------------------------------------------------------
// barometric_pressure_compensation
// pipelined integer compensation of temperature and pressure
// ---------------------------------------------------------------------------
module barometric_pressure_compensation #(
    parameter int CFG_IW = bpc_pkg::CFG_IW
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IW-1:0]           i_cfg_idx,
    input  logic [bpc_pkg::CFG_DW-1:0]  i_cfg_data,
    bpc_in_if.sink                      i_in,
    bpc_out_if.source                   o_out
);
    import bpc_pkg::*;

    logic [63:0] r_cal_a;
    logic [63:0] r_cal_b;
    logic [31:0] r_cal_c;
    logic [1:0]  r_oss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
            r_oss   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx[CFG_IW-1:0])
                CFG_IW'(REG_CAL_A): r_cal_a <= i_cfg_data;
                CFG_IW'(REG_CAL_B): r_cal_b <= i_cfg_data;
                CFG_IW'(REG_CAL_C): r_cal_c <= i_cfg_data[31:0];
                CFG_IW'(REG_OSS):   r_oss   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic [DW-1:0] c1, c2, c3, c4, c5, c6, k1, k2, kc, kd;
    assign c1 = sx16(r_cal_a[15:0]);
    assign c2 = sx16(r_cal_a[31:16]);
    assign c3 = sx16(r_cal_a[47:32]);
    assign c4 = {16'd0, r_cal_a[63:48]};
    assign c5 = {16'd0, r_cal_b[15:0]};
    assign c6 = {16'd0, r_cal_b[31:16]};
    assign k1 = sx16(r_cal_b[47:32]);
    assign k2 = sx16(r_cal_b[63:48]);
    assign kc = sx16(r_cal_c[15:0]);
    assign kd = sx16(r_cal_c[31:16]);

    logic en;
    assign en = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    // stage 1: temperature product
    logic                r1_v;
    logic [DW-1:0]       r1_p;
    logic [UP_W-1:0]     r1_up;
    // stage 2: divider operands
    logic                r2_v;
    logic [DW-1:0]       r2_a, r2_mn, r2_md;
    logic                r2_neg, r2_z;
    logic [UP_W-1:0]     r2_up;

    logic [DW-1:0] s2_a, s2_den, s2_num;
    assign s2_a   = sra(r1_p, 15);
    assign s2_den = s2_a + kd;
    assign s2_num = kc << 11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in.valid;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_p   <= ({16'd0, i_in.raw_temperature} - c6) * c5;
            r1_up  <= i_in.raw_pressure;
            r2_a   <= s2_a;
            r2_mn  <= s2_num[DW-1] ? -s2_num : s2_num;
            r2_md  <= s2_den[DW-1] ? -s2_den : s2_den;
            r2_neg <= s2_num[DW-1] ^ s2_den[DW-1];
            r2_z   <= (s2_den == '0);
            r2_up  <= r1_up;
        end
    end

    localparam int SB1_W = DW + 2 + UP_W;
    logic              d1_v;
    logic [DW-1:0]     d1_q;
    logic [SB1_W-1:0]  d1_sb;

    bpc_div #(.SB_W(SB1_W)) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r2_v),
        .i_num   (r2_mn),
        .i_den   (r2_md),
        .i_sb    ({r2_a, r2_neg, r2_z, r2_up}),
        .o_vld   (d1_v),
        .o_quo   (d1_q),
        .o_sb    (d1_sb)
    );

    logic [DW-1:0]   d1_a;
    logic            d1_neg, d1_z;
    logic [UP_W-1:0] d1_up;
    assign {d1_a, d1_neg, d1_z, d1_up} = d1_sb;

    logic [DW-1:0] s3_t5;
    assign s3_t5 = d1_a + (d1_neg ? -d1_q : d1_q);

    // stages 3..8: pressure coefficients
    logic r3_v, r4_v, r5_v, r6_v, r7_v, r8_v;
    logic [DW-1:0] r3_t, r3_t6, r4_t, r5_t, r6_t, r7_t, r8_t;
    logic r3_z, r4_z, r5_z, r6_z, r7_z, r8_z;
    logic [UP_W-1:0] r3_up, r4_up, r5_up, r6_up;
    logic [DW-1:0] r4_sq, r4_c2, r4_c3;
    logic [DW-1:0] r5_mk2, r5_mk1, r5_b, r5_a;
    logic [DW-1:0] r6_t3, r6_s;
    logic [DW-1:0] r7_t4, r7_t7;
    logic [DW-1:0] r8_num, r8_den;
    logic r8_shl;

    logic [DW-1:0] s5_sq, s6_s, s6_s2;
    assign s5_sq = sra(r4_sq, 12);
    assign s6_s  = sra(r5_mk2, 11) + r5_b;
    assign s6_s2 = sra(r5_a + sra(r5_mk1, 16) + 32'd2, 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r3_v, r4_v, r5_v, r6_v, r7_v, r8_v} <= '0;
        end else if (en) begin
            {r3_v, r4_v, r5_v, r6_v, r7_v, r8_v} <= {d1_v, r3_v, r4_v, r5_v, r6_v, r7_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_t   <= sra(s3_t5 + 32'd8, 4);
            r3_t6  <= s3_t5 - T6_OFS;
            r3_z   <= d1_z;
            r3_up  <= d1_up;

            r4_sq  <= r3_t6 * r3_t6;
            r4_c2  <= c2 * r3_t6;
            r4_c3  <= c3 * r3_t6;
            r4_t   <= r3_t;
            r4_z   <= r3_z;
            r4_up  <= r3_up;

            r5_mk2 <= k2 * s5_sq;
            r5_mk1 <= k1 * s5_sq;
            r5_b   <= sra(r4_c2, 11);
            r5_a   <= sra(r4_c3, 13);
            r5_t   <= r4_t;
            r5_z   <= r4_z;
            r5_up  <= r4_up;

            r6_t3  <= sra(((c1 * 32'd4 + s6_s) << r_oss) + 32'd2, 2);
            r6_s   <= s6_s2 + S_OFS;
            r6_t   <= r5_t;
            r6_z   <= r5_z;
            r6_up  <= r5_up;

            r7_t4  <= (c4 * r6_s) >> 15;
            r7_t7  <= ({{(DW-UP_W){1'b0}}, r6_up} - r6_t3) * (P_SCALE >> r_oss);
            r7_t   <= r6_t;
            r7_z   <= r6_z;

            r8_shl <= (r7_t7 & SIGN_BIT) != '0;
            r8_num <= ((r7_t7 & SIGN_BIT) != '0) ? r7_t7 : (r7_t7 << 1);
            r8_den <= r7_t4;
            r8_z   <= r7_z || (r7_t4 == '0);
            r8_t   <= r7_t;
        end
    end

    localparam int SB2_W = DW + 2;
    logic              d2_v;
    logic [DW-1:0]     d2_q;
    logic [SB2_W-1:0]  d2_sb;

    bpc_div #(.SB_W(SB2_W)) u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r8_v),
        .i_num   (r8_num),
        .i_den   (r8_den),
        .i_sb    ({r8_t, r8_shl, r8_z}),
        .o_vld   (d2_v),
        .o_quo   (d2_q),
        .o_sb    (d2_sb)
    );

    logic [DW-1:0] d2_t;
    logic          d2_shl, d2_z;
    assign {d2_t, d2_shl, d2_z} = d2_sb;

    // stages 9..12: pressure polynomial and output
    logic r9_v, r10_v, r11_v, r12_v;
    logic [DW-1:0] r9_p, r9_a, r10_p, r10_aa, r10_bb, r11_p, r11_a2, r11_b;
    logic [DW-1:0] r9_t, r10_t, r11_t;
    logic r9_z, r10_z, r11_z;
    logic [DW-1:0] s9_p;
    assign s9_p = d2_shl ? (d2_q << 1) : d2_q;

    logic [DW-1:0] s12_p;
    logic [TO_W-1:0] s12_t;
    assign s12_p = r11_p + sra(sra(r11_a2, 16) + r11_b + K_OFS, 4);
    always_comb begin
        if ($signed(r11_t) > 32'sd32767) begin
            s12_t = 16'h7FFF;
        end else if ($signed(r11_t) < -32'sd32768) begin
            s12_t = 16'h8000;
        end else begin
            s12_t = r11_t[TO_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r9_v, r10_v, r11_v, r12_v} <= '0;
        end else if (en) begin
            {r9_v, r10_v, r11_v, r12_v} <= {d2_v, r9_v, r10_v, r11_v};
        end
    end

    logic [TO_W-1:0] r12_tmp;
    logic [DW-1:0]   r12_prs;
    logic            r12_err;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_p   <= s9_p;
            r9_a   <= sra(s9_p, 8);
            r9_t   <= d2_t;
            r9_z   <= d2_z;

            r10_aa <= r9_a * r9_a;
            r10_bb <= K_LIN * r9_p;
            r10_p  <= r9_p;
            r10_t  <= r9_t;
            r10_z  <= r9_z;

            r11_a2 <= r10_aa * K_SQ;
            r11_b  <= sra(r10_bb, 16);
            r11_p  <= r10_p;
            r11_t  <= r10_t;
            r11_z  <= r10_z;

            r12_tmp <= r11_z ? '0 : s12_t;
            r12_prs <= r11_z ? '0 : s12_p;
            r12_err <= r11_z;
        end
    end

    assign o_out.valid                   = r12_v;
    assign o_out.temperature_decidegrees = r12_tmp;
    assign o_out.pressure_pascal         = r12_prs;
    assign o_out.divide_error            = r12_err;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.divide_error) |->
            (o_out.pressure_pascal == '0 && o_out.temperature_decidegrees == '0))
        else $error("error beat with nonzero fields");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled with empty output");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(r9_p) && $stable(r3_t)))
        else $error("pipeline moved during stall");

endmodule
